@@ hw/rtl/slps_pkg.sv @@
// Shared types and constants for the sensor line parser and steering block.
package slps_pkg;

   // Packet parse position
   typedef enum logic [3:0] {
      PH_D      = 4'd0,
      PH_A1     = 4'd1,
      PH_T      = 4'd2,
      PH_A2     = 4'd3,
      PH_COLON  = 4'd4,
      PH_DIGIT1 = 4'd5,
      PH_DIGITS = 4'd6,
      PH_CR     = 4'd7,
      PH_LF     = 4'd8
   } phase_type;

   // Steering commands
   typedef enum logic [1:0] {
      STEER_HALT  = 2'd0,
      STEER_LEFT  = 2'd1,
      STEER_AHEAD = 2'd2
   } move_type;

   // Control register indexes
   localparam logic [1:0] CSR_STOP_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_LEFT_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_UPPER_BOUND = 2'd2;

   localparam logic [6:0] STOP_LIMIT_RST  = 7'd15;
   localparam logic [6:0] LEFT_LIMIT_RST  = 7'd40;
   localparam logic [6:0] UPPER_BOUND_RST = 7'd100;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [6:0] DIST_SAT = 7'd100;

   typedef struct packed {
      logic [6:0] stop_limit;
      logic [6:0] left_limit;
      logic [6:0] upper_bound;
   } cfg_type;

   typedef struct packed {
      logic [6:0] distance;
      logic       parse_error;
      move_type   movement;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } step_res_type;

endpackage

@@ hw/rtl/sensor_line_parser_steering.sv @@
// Sensor line parser top level: byte stream in, steering result out.
// An accepted byte passes the input register, then the result register, to its result
// word; bytes that do not close a packet give no word.
// Throughput: one byte per cycle while the result side is not stalled, set by the parse state update.
// Reset (synchronous, active high) clears the packet state and both pipeline
// registers and loads the limits with 15, 40 and 100.
module sensor_line_parser_steering
   import slps_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] movement, [2] parse_error, [9:3] distance
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wr_data
);

   cfg_type      cfg_ff;
   logic         s1_valid_ff;
   logic [7:0]   s1_byte_ff;
   logic         out_valid_ff;
   rsp_type      out_ff;
   logic         advance;
   logic         step;
   step_res_type res;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_limit  <= STOP_LIMIT_RST;
         cfg_ff.left_limit  <= LEFT_LIMIT_RST;
         cfg_ff.upper_bound <= UPPER_BOUND_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STOP_LIMIT:  cfg_ff.stop_limit  <= csr_wr_data;
            CSR_LEFT_LIMIT:  cfg_ff.left_limit  <= csr_wr_data;
            CSR_UPPER_BOUND: cfg_ff.upper_bound <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Hold the incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (step) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   slps_core #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (s1_byte_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   // Result register; drop the word once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= res.valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         out_ff <= res.data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff.distance, out_ff.parse_error, out_ff.movement};

`ifndef NO_ASSERTIONS
   // An error word always commands stop
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.parse_error |-> out_ff.movement == STEER_HALT)
      else $error("error word carries a movement");

   // Distance never passes the saturation value
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.distance <= DIST_SAT)
      else $error("distance beyond saturation");

   // A clean word has a distance inside the accepted window
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.parse_error |->
         (out_ff.distance != 7'd0) && (out_ff.distance < cfg_ff.upper_bound))
      else $error("clean word with distance out of window");

   // Reset empties the pipeline
   assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

@@ hw/rtl/slps_core.sv @@
// Packet framing, prefix and digit parsing, and steering classification.
module slps_core
   import slps_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   rx_byte,
   input  cfg_type      cfg,
   output step_res_type res
);

   localparam logic [3:0] MaxBytes = 4'(MAX_PACKET_BYTES);

   logic [3:0] count_ff, count_in;
   phase_type  phase_ff, phase_in;
   logic [6:0] acc_ff, acc_in;
   logic       bad_ff, bad_in;
   logic       ended_ff, ended_in;
   logic       fzero_ff, fzero_in;

   logic        is_digit;
   logic [10:0] acc_mac;
   logic [6:0]  acc_digit;
   logic        pkt_end;
   logic        form_ok;

   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign acc_mac   = {4'b0, acc_ff} * 11'd10 + {7'b0, rx_byte[3:0]};
   assign acc_digit = (acc_mac > {4'b0, DIST_SAT}) ? DIST_SAT : acc_mac[6:0];

   // Next parse state for this byte, before end-of-packet clearing
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      bad_in   = bad_ff;
      ended_in = ended_ff;
      fzero_in = fzero_ff;
      count_in = count_ff + 4'd1;
      if (!ended_ff) begin
         if (rx_byte == CHAR_NUL) begin
            ended_in = 1'b1;
            if (count_ff == 4'd0) begin
               fzero_in = 1'b1;
            end
         end else if (!bad_ff) begin
            case (phase_ff)
               PH_D: begin
                  if (rx_byte == CHAR_D) phase_in = PH_A1;
                  else bad_in = 1'b1;
               end
               PH_A1: begin
                  if (rx_byte == CHAR_A) phase_in = PH_T;
                  else bad_in = 1'b1;
               end
               PH_T: begin
                  if (rx_byte == CHAR_T) phase_in = PH_A2;
                  else bad_in = 1'b1;
               end
               PH_A2: begin
                  if (rx_byte == CHAR_A) phase_in = PH_COLON;
                  else bad_in = 1'b1;
               end
               PH_COLON: begin
                  if (rx_byte == CHAR_COLON) phase_in = PH_DIGIT1;
                  else bad_in = 1'b1;
               end
               PH_DIGIT1: begin
                  if (is_digit) begin
                     acc_in   = acc_digit;
                     phase_in = PH_DIGITS;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) acc_in = acc_digit;
                  else if (rx_byte == CHAR_CR) phase_in = PH_CR;
                  else bad_in = 1'b1;
               end
               PH_CR: begin
                  if (rx_byte == CHAR_LF) phase_in = PH_LF;
                  else bad_in = 1'b1;
               end
               default: bad_in = 1'b1;
            endcase
         end
      end
   end

   // Packet closes on newline or at the byte limit
   assign pkt_end = (rx_byte == CHAR_LF) || (count_in >= MaxBytes);
   assign form_ok = !bad_in && ((phase_in == PH_DIGITS) || (phase_in == PH_LF));

   // Classify the closing packet
   always_comb begin
      res.valid            = pkt_end && !fzero_in;
      res.data.movement    = STEER_HALT;
      res.data.parse_error = 1'b1;
      res.data.distance    = 7'd0;
      if (form_ok) begin
         res.data.distance = acc_in;
         if ((acc_in != 7'd0) && (acc_in < cfg.upper_bound)) begin
            res.data.parse_error = 1'b0;
            if (acc_in <= cfg.stop_limit) res.data.movement = STEER_HALT;
            else if (acc_in <= cfg.left_limit) res.data.movement = STEER_LEFT;
            else res.data.movement = STEER_AHEAD;
         end
      end
   end

   // Advance parse state; clear it when the packet closes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         phase_ff <= PH_D;
         acc_ff   <= 7'd0;
         bad_ff   <= 1'b0;
         ended_ff <= 1'b0;
         fzero_ff <= 1'b0;
      end else if (step) begin
         if (pkt_end) begin
            count_ff <= 4'd0;
            phase_ff <= PH_D;
            acc_ff   <= 7'd0;
            bad_ff   <= 1'b0;
            ended_ff <= 1'b0;
            fzero_ff <= 1'b0;
         end else begin
            count_ff <= count_in;
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            bad_ff   <= bad_in;
            ended_ff <= ended_in;
            fzero_ff <= fzero_in;
         end
      end
   end

endmodule
